// ----- rtl/core/ddps_pkg.sv -----
package ddps_pkg;

    // Clock of the step generators, in hertz
    localparam int unsigned CLOCK_HZ   = 2000000;
    localparam int unsigned RATE_FLOOR = 31;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int ERR_W    = SAMPLE_W + 1;
    localparam int DER_W    = ERR_W + 1;
    localparam int GAIN_W   = 16;
    localparam int STEER_W  = 31;
    localparam int BASE_W   = 12;
    localparam int AMT_W    = STEER_W - 4;
    localparam int RATE_W   = AMT_W + 1;
    localparam int PERIOD_W = 16;
    localparam int DUTY_W   = PERIOD_W - 1;

    // Period divider sizing
    localparam int CLK_W     = $clog2(CLOCK_HZ + 1);
    localparam int DIV_CNT_W = $clog2(CLK_W);

    // Stream payload sizes
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 64;

    // Configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] REG_MID_TARGET      = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] REG_LEFT_THRESHOLD  = CFG_AW'(1);
    localparam logic [CFG_AW-1:0] REG_RIGHT_THRESHOLD = CFG_AW'(2);
    localparam logic [CFG_AW-1:0] REG_PROP_GAIN       = CFG_AW'(3);
    localparam logic [CFG_AW-1:0] REG_DERIV_GAIN      = CFG_AW'(4);
    localparam logic [CFG_AW-1:0] REG_BASE_RATE       = CFG_AW'(5);
    localparam logic [CFG_AW-1:0] REG_MIN_RATE        = CFG_AW'(6);
    localparam logic [CFG_AW-1:0] REG_MAX_RATE        = CFG_AW'(7);

    // Register reset values
    localparam logic [SAMPLE_W-1:0] RST_MID_TARGET      = SAMPLE_W'(3102);
    localparam logic [SAMPLE_W-1:0] RST_LEFT_THRESHOLD  = SAMPLE_W'(3412);
    localparam logic [SAMPLE_W-1:0] RST_RIGHT_THRESHOLD = SAMPLE_W'(3102);
    localparam logic [GAIN_W-1:0]   RST_PROP_GAIN       = GAIN_W'(53);
    localparam logic [GAIN_W-1:0]   RST_DERIV_GAIN      = GAIN_W'(0);
    localparam logic [BASE_W-1:0]   RST_BASE_RATE       = BASE_W'(218);
    localparam logic [BASE_W-1:0]   RST_MIN_RATE        = BASE_W'(85);
    localparam logic [BASE_W-1:0]   RST_MAX_RATE        = BASE_W'(351);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEER,
        ST_SCALE,
        ST_CLAMP,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

// ----- rtl/core/ddps_div.sv -----
// Restoring divider: CLOCK_HZ / divisor, one quotient bit per cycle.
module ddps_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ddps_pkg::BASE_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [ddps_pkg::PERIOD_W-1:0] o_quot
);
    import ddps_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CLK_W-1:0]     r_num;
    logic [BASE_W-1:0]    r_rem;
    logic [BASE_W-1:0]    r_div;
    logic [PERIOD_W-1:0]  r_quot;

    logic [BASE_W:0]      n_trial;
    logic                 n_fit;

    // Bring down the next numerator bit and try the subtract
    always_comb begin
        n_trial = {r_rem, r_num[CLK_W-1]};
        n_fit   = (n_trial >= {1'b0, r_div});
    end

    // Control: busy flag, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(CLK_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift numerator out, quotient in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= CLK_W'(CLOCK_HZ);
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[CLK_W-2:0], 1'b0};
            r_rem  <= n_fit ? BASE_W'(n_trial - {1'b0, r_div}) : n_trial[BASE_W-1:0];
            r_quot <= {r_quot[PERIOD_W-2:0], n_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- rtl/core/differential_drive_pd_steering.sv -----
// PD steering for a two-wheel line follower. Each input beat carries the left,
// middle and right reflectance codes; each output beat carries the step period
// (clock counts) and high time of both wheels. The error is mid minus the set
// point, the derivative is the change of error since the previous beat, and the
// steer amount scales the base rate. Rates are clamped to [min,max] (registers
// below 31 count as 31). A left sensor below its threshold stops the left wheel
// and runs the right at max rate; the right sensor does the reverse and wins.
// One item is worked at a time; from accept to result it passes a bit-serial
// gain multiply, a bit-serial base-rate multiply, a clamp step and the two
// parallel restoring period dividers. A finished result waits in the output
// register while the next beat is taken. Configuration writes are always
// ready and must be made while the block idles.
module differential_drive_pd_steering (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ddps_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  logic [ddps_pkg::CFG_DW-1:0]      i_cfg_data,
    // Sensor stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // left_sample[11:0], mid_sample[23:12], right_sample[35:24], zero pad
    input  logic [ddps_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Wheel stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // right_period[15:0], right_duty[30:16], left_period[46:31],
    // left_duty[61:47], zero pad
    output logic [ddps_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import ddps_pkg::*;

    // Configuration registers
    logic [SAMPLE_W-1:0] r_mid_target;
    logic [SAMPLE_W-1:0] r_left_thr;
    logic [SAMPLE_W-1:0] r_right_thr;
    logic [GAIN_W-1:0]   r_prop_gain;
    logic [GAIN_W-1:0]   r_deriv_gain;
    logic [BASE_W-1:0]   r_base_rate;
    logic [BASE_W-1:0]   r_min_rate;
    logic [BASE_W-1:0]   r_max_rate;

    // Sequencer
    t_state r_state;
    t_state n_state;
    logic [3:0] r_cnt;
    logic       in_fire;
    logic       div_start;
    logic       out_load;

    // Item datapath
    logic signed [ERR_W-1:0]   r_prev_err;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [DER_W-1:0]   r_der;
    logic                      r_trig_l;
    logic                      r_trig_r;
    logic [GAIN_W-1:0]         r_kp_sh;
    logic [GAIN_W-1:0]         r_kd_sh;
    logic [BASE_W-1:0]         r_base_sh;
    logic signed [STEER_W-1:0] r_steer;
    logic signed [STEER_W-1:0] r_hi;
    logic                      r_stop_l;
    logic                      r_stop_r;

    logic [SAMPLE_W-1:0]       in_left;
    logic [SAMPLE_W-1:0]       in_mid;
    logic [SAMPLE_W-1:0]       in_right;
    logic signed [ERR_W-1:0]   n_err;
    logic signed [STEER_W-1:0] n_steer;
    logic signed [STEER_W:0]   n_hi_sum;
    logic signed [AMT_W-1:0]   amount;
    logic signed [RATE_W-1:0]  rate_r;
    logic signed [RATE_W-1:0]  rate_l;
    logic [BASE_W-1:0]         lo_rate;
    logic [BASE_W-1:0]         hi_rate;
    logic [BASE_W-1:0]         divisor_r;
    logic [BASE_W-1:0]         divisor_l;
    logic                      stop_r;
    logic                      stop_l;

    logic                      done_r;
    logic                      done_l;
    logic [PERIOD_W-1:0]       quot_r;
    logic [PERIOD_W-1:0]       quot_l;

    logic                      r_m_valid;
    logic [OUT_TDATA_W-1:0]    r_m_data;

    // Clamp a signed rate to [lo, hi], low bound checked first
    function automatic logic [BASE_W-1:0] clamp_rate(
        input logic signed [RATE_W-1:0] rate,
        input logic [BASE_W-1:0]        lo,
        input logic [BASE_W-1:0]        hi
    );
        logic [BASE_W-1:0] res;
        if (rate <= $signed({{(RATE_W-BASE_W){1'b0}}, lo}))
            res = lo;
        else if (rate >= $signed({{(RATE_W-BASE_W){1'b0}}, hi}))
            res = hi;
        else
            res = rate[BASE_W-1:0];
        return res;
    endfunction

    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_target <= RST_MID_TARGET;
            r_left_thr   <= RST_LEFT_THRESHOLD;
            r_right_thr  <= RST_RIGHT_THRESHOLD;
            r_prop_gain  <= RST_PROP_GAIN;
            r_deriv_gain <= RST_DERIV_GAIN;
            r_base_rate  <= RST_BASE_RATE;
            r_min_rate   <= RST_MIN_RATE;
            r_max_rate   <= RST_MAX_RATE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_MID_TARGET:      r_mid_target <= i_cfg_data[SAMPLE_W-1:0];
                REG_LEFT_THRESHOLD:  r_left_thr   <= i_cfg_data[SAMPLE_W-1:0];
                REG_RIGHT_THRESHOLD: r_right_thr  <= i_cfg_data[SAMPLE_W-1:0];
                REG_PROP_GAIN:       r_prop_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:      r_deriv_gain <= i_cfg_data[GAIN_W-1:0];
                REG_BASE_RATE:       r_base_rate  <= i_cfg_data[BASE_W-1:0];
                REG_MIN_RATE:        r_min_rate   <= i_cfg_data[BASE_W-1:0];
                REG_MAX_RATE:        r_max_rate   <= i_cfg_data[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_STEER;
            ST_STEER: if (r_cnt == 4'(GAIN_W - 1)) n_state = ST_SCALE;
            ST_SCALE: if (r_cnt == 4'(BASE_W - 1)) n_state = ST_CLAMP;
            ST_CLAMP: n_state = ST_DIV;
            ST_DIV:   if (done_r && done_l) n_state = ST_OUT;
            ST_OUT:   if (!r_m_valid || m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_CLAMP: div_start     = 1'b1;
            ST_OUT:   out_load      = !r_m_valid || m_axis_tready;
            default: ;
        endcase
    end

    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state)
                r_cnt <= '0;
            else
                r_cnt <= r_cnt + 1'b1;
        end
    end

    // Unpack the sensor beat
    assign in_left  = s_axis_tdata[SAMPLE_W-1:0];
    assign in_mid   = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign in_right = s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
    assign n_err    = $signed({1'b0, in_mid}) - $signed({1'b0, r_mid_target});

    // Previous error is state that survives between items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_prev_err <= '0;
        else if (in_fire)
            r_prev_err <= n_err;
    end

    // Gain multiply step, MSB first: acc = 2*acc + kp_bit*e - kd_bit*d
    always_comb begin
        n_steer = r_steer <<< 1;
        if (r_kp_sh[GAIN_W-1])
            n_steer = n_steer + STEER_W'(r_err);
        if (r_kd_sh[GAIN_W-1])
            n_steer = n_steer - STEER_W'(r_der);
    end

    // Base-rate multiply step, LSB first; low product bits fall away
    assign n_hi_sum = (STEER_W + 1)'(r_hi)
                    + (r_base_sh[0] ? (STEER_W + 1)'(r_steer) : '0);

    // Amount is the product floored by 2^16: high part over 16
    assign amount = r_hi[STEER_W-1:4];
    assign rate_r = $signed({{(RATE_W-BASE_W){1'b0}}, r_base_rate}) + RATE_W'(amount);
    assign rate_l = $signed({{(RATE_W-BASE_W){1'b0}}, r_base_rate}) - RATE_W'(amount);
    assign lo_rate = (r_min_rate < BASE_W'(RATE_FLOOR)) ? BASE_W'(RATE_FLOOR) : r_min_rate;
    assign hi_rate = (r_max_rate < BASE_W'(RATE_FLOOR)) ? BASE_W'(RATE_FLOOR) : r_max_rate;

    // Pick divisors; a hard turn overrides the steered rates
    always_comb begin
        divisor_r = clamp_rate(rate_r, lo_rate, hi_rate);
        divisor_l = clamp_rate(rate_l, lo_rate, hi_rate);
        stop_r    = 1'b0;
        stop_l    = 1'b0;
        if (r_trig_r) begin
            divisor_r = lo_rate;
            divisor_l = hi_rate;
            stop_r    = 1'b1;
        end else if (r_trig_l) begin
            divisor_r = hi_rate;
            divisor_l = lo_rate;
            stop_l    = 1'b1;
        end
    end

    // Item datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_err     <= n_err;
            r_der     <= DER_W'(n_err) - DER_W'(r_prev_err);
            r_trig_l  <= in_left < r_left_thr;
            r_trig_r  <= in_right < r_right_thr;
            r_kp_sh   <= r_prop_gain;
            r_kd_sh   <= r_deriv_gain;
            r_base_sh <= r_base_rate;
            r_steer   <= '0;
            r_hi      <= '0;
        end else begin
            unique case (r_state)
                ST_STEER: begin
                    r_steer <= n_steer;
                    r_kp_sh <= {r_kp_sh[GAIN_W-2:0], 1'b0};
                    r_kd_sh <= {r_kd_sh[GAIN_W-2:0], 1'b0};
                end
                ST_SCALE: begin
                    r_hi      <= n_hi_sum[STEER_W:1];
                    r_base_sh <= {1'b0, r_base_sh[BASE_W-1:1]};
                end
                ST_CLAMP: begin
                    r_stop_r <= stop_r;
                    r_stop_l <= stop_l;
                end
                default: ;
            endcase
        end
    end

    // Period dividers, one per wheel, run side by side
    ddps_div u_div_r (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (divisor_r),
        .o_done    (done_r),
        .o_quot    (quot_r)
    );

    ddps_div u_div_l (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (divisor_l),
        .o_done    (done_l),
        .o_quot    (quot_l)
    );

    // Output register: hold the beat until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= {
                2'b00,
                r_stop_l ? DUTY_W'(0) : quot_l[PERIOD_W-1:1],
                quot_l,
                r_stop_r ? DUTY_W'(0) : quot_r[PERIOD_W-1:1],
                quot_r
            };
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
    import ddps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles to let pass after the last wheel beat before reconfiguring or ending
    localparam int DRAIN_CYCLES = 80;
    localparam int SCANS_PER_PHASE = 150;
    localparam int RANDOM_PHASES = 13;

    // Wheel command as packed on the master tdata, first field in the top bits
    typedef struct packed {
        logic [DUTY_W-1:0]   left_duty;
        logic [PERIOD_W-1:0] left_period;
        logic [DUTY_W-1:0]   right_duty;
        logic [PERIOD_W-1:0] right_period;
    } t_wheel_cmd;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_AW-1:0]      i_cfg_addr = '0;
    logic [CFG_DW-1:0]      i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Pending sensor scans and the wheel commands they must produce
    logic [IN_TDATA_W-1:0]  scan_q[$];
    t_wheel_cmd             wheel_q[$];
    int                     fail_count = 0;

    // Register copies as seen by the block
    logic [SAMPLE_W-1:0]    cur_mid_target;
    logic [SAMPLE_W-1:0]    cur_left_thr;
    logic [SAMPLE_W-1:0]    cur_right_thr;
    logic [GAIN_W-1:0]      cur_prop_gain;
    logic [GAIN_W-1:0]      cur_deriv_gain;
    logic [BASE_W-1:0]      cur_base_rate;
    logic [BASE_W-1:0]      cur_min_rate;
    logic [BASE_W-1:0]      cur_max_rate;
    longint                 last_error;

    // Intended setting, used to shape the scans
    int plan_mid = RST_MID_TARGET;
    int plan_lthr = RST_LEFT_THRESHOLD;
    int plan_rthr = RST_RIGHT_THRESHOLD;

    // Sender burst state
    int burst_left = 0;
    int gap_left = 0;

    // Receiver stall state
    int stall_left = 0;
    int sink_mode = 0;
    int mode_left = 0;

    differential_drive_pd_steering u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Clamp a wheel rate and turn it into a step period
    function automatic logic [PERIOD_W-1:0] wheel_period(input longint rate);
        longint lo;
        longint hi;
        longint pick;
        lo = (cur_min_rate < RATE_FLOOR) ? RATE_FLOOR : cur_min_rate;
        hi = (cur_max_rate < RATE_FLOOR) ? RATE_FLOOR : cur_max_rate;
        if (rate <= lo)
            pick = lo;
        else if (rate >= hi)
            pick = hi;
        else
            pick = rate;
        return PERIOD_W'(longint'(CLOCK_HZ) / pick);
    endfunction

    // Work out the wheel command for one scan and advance the error history
    function automatic t_wheel_cmd steer_wheels(input logic [IN_TDATA_W-1:0] beat);
        longint left_s;
        longint mid_s;
        longint right_s;
        longint err;
        longint der;
        longint steer;
        longint amount;
        logic [PERIOD_W-1:0] slow;
        logic [PERIOD_W-1:0] fast;
        logic [PERIOD_W-1:0] rp;
        logic [PERIOD_W-1:0] lp;
        t_wheel_cmd cmd;
        left_s  = longint'(beat[11:0]);
        mid_s   = longint'(beat[23:12]);
        right_s = longint'(beat[35:24]);
        err = mid_s - longint'(cur_mid_target);
        der = err - last_error;
        last_error = err;
        steer = longint'(cur_prop_gain) * err - longint'(cur_deriv_gain) * der;
        // Arithmetic shift floors toward minus infinity
        amount = (longint'(cur_base_rate) * steer) >>> 16;
        rp = wheel_period(longint'(cur_base_rate) + amount);
        lp = wheel_period(longint'(cur_base_rate) - amount);
        cmd.right_period = rp;
        cmd.right_duty   = DUTY_W'(rp >> 1);
        cmd.left_period  = lp;
        cmd.left_duty    = DUTY_W'(lp >> 1);
        slow = PERIOD_W'(CLOCK_HZ / ((cur_min_rate < RATE_FLOOR) ? RATE_FLOOR : cur_min_rate));
        fast = PERIOD_W'(CLOCK_HZ / ((cur_max_rate < RATE_FLOOR) ? RATE_FLOOR : cur_max_rate));
        // Hard turns; the right sensor wins when both fire
        if (left_s < longint'(cur_left_thr)) begin
            cmd.left_period  = slow;
            cmd.left_duty    = '0;
            cmd.right_period = fast;
            cmd.right_duty   = DUTY_W'(fast >> 1);
        end
        if (right_s < longint'(cur_right_thr)) begin
            cmd.left_period  = fast;
            cmd.left_duty    = DUTY_W'(fast >> 1);
            cmd.right_period = slow;
            cmd.right_duty   = '0;
        end
        return cmd;
    endfunction

    // Track register writes and predict every accepted scan
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_mid_target = RST_MID_TARGET;
            cur_left_thr   = RST_LEFT_THRESHOLD;
            cur_right_thr  = RST_RIGHT_THRESHOLD;
            cur_prop_gain  = RST_PROP_GAIN;
            cur_deriv_gain = RST_DERIV_GAIN;
            cur_base_rate  = RST_BASE_RATE;
            cur_min_rate   = RST_MIN_RATE;
            cur_max_rate   = RST_MAX_RATE;
            last_error     = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_addr)
                    REG_MID_TARGET:      cur_mid_target = i_cfg_data[SAMPLE_W-1:0];
                    REG_LEFT_THRESHOLD:  cur_left_thr   = i_cfg_data[SAMPLE_W-1:0];
                    REG_RIGHT_THRESHOLD: cur_right_thr  = i_cfg_data[SAMPLE_W-1:0];
                    REG_PROP_GAIN:       cur_prop_gain  = i_cfg_data[GAIN_W-1:0];
                    REG_DERIV_GAIN:      cur_deriv_gain = i_cfg_data[GAIN_W-1:0];
                    REG_BASE_RATE:       cur_base_rate  = i_cfg_data[BASE_W-1:0];
                    REG_MIN_RATE:        cur_min_rate   = i_cfg_data[BASE_W-1:0];
                    REG_MAX_RATE:        cur_max_rate   = i_cfg_data[BASE_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                wheel_q.push_back(steer_wheels(s_axis_tdata));
        end
    end

    // Sensor driver: bursts of beats with random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left != 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (scan_q.size() != 0) begin
                s_axis_tdata  <= scan_q.pop_front();
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(12, 1);
                    gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(60, 1);
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= 40)
                $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Wheel monitor: compare each beat, then pick the next ready level
    always @(posedge i_clk) begin
        t_wheel_cmd got;
        t_wheel_cmd want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[$bits(t_wheel_cmd)-1:0];
                check_field("tdata pad", 0, m_axis_tdata[OUT_TDATA_W-1:$bits(t_wheel_cmd)]);
                if (wheel_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 40)
                        $display("%0t ns: wheel beat with none expected, got %h",
                                 $time, m_axis_tdata);
                end else begin
                    want = wheel_q.pop_front();
                    check_field("right_period", want.right_period, got.right_period);
                    check_field("right_duty", want.right_duty, got.right_duty);
                    check_field("left_period", want.left_period, got.left_period);
                    check_field("left_duty", want.left_duty, got.left_duty);
                end
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(800, 200);
                sink_mode = $urandom_range(2, 0);
            end else begin
                mode_left--;
            end
            if (stall_left != 0) begin
                stall_left--;
            end else begin
                case (sink_mode)
                    0: m_axis_tready <= 1'b1;
                    1: begin
                        m_axis_tready <= 1'($urandom_range(1, 0));
                        stall_left = $urandom_range(3, 0);
                    end
                    default: begin
                        if (m_axis_tready) begin
                            m_axis_tready <= 1'b0;
                            stall_left = $urandom_range(60, 5);
                        end else begin
                            m_axis_tready <= 1'b1;
                            stall_left = $urandom_range(4, 0);
                        end
                    end
                endcase
            end
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pack_scan(input logic [11:0] l,
                                                        input logic [11:0] m,
                                                        input logic [11:0] r);
        return {4'b0, r, m, l};
    endfunction

    // Edge sensor code, mostly at or above its threshold
    function automatic int edge_code(input int thr);
        if (thr == 0 || $urandom_range(7, 0) != 0)
            return $urandom_range(4095, thr);
        return $urandom_range(thr - 1, 0);
    endfunction

    function automatic int rand_gain();
        case ($urandom_range(3, 0))
            0: return $urandom_range(100, 0);
            1: return $urandom_range(1500, 0);
            2: return $urandom_range(65535, 0);
            default: return $urandom_range(1, 0) ? 65535 : 0;
        endcase
    endfunction

    function automatic int rand_thr();
        case ($urandom_range(3, 0))
            0: return 0;
            1: return $urandom_range(400, 0);
            2: return $urandom_range(4095, 0);
            default: return $urandom_range(1500, 0);
        endcase
    endfunction

    function automatic int rand_rate();
        if ($urandom_range(1, 0) == 0)
            return $urandom_range(600, 31);
        return $urandom_range(4095, 0);
    endfunction

    // One register write beat
    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Write all registers; unused upper data bits of narrow registers get noise
    task automatic set_all(input int mt, input int lt, input int rt, input int pg,
                           input int dg, input int br, input int mn, input int mx);
        plan_mid  = mt;
        plan_lthr = lt;
        plan_rthr = rt;
        write_reg(REG_MID_TARGET, {4'($urandom), 12'(mt)});
        write_reg(REG_LEFT_THRESHOLD, {4'($urandom), 12'(lt)});
        write_reg(REG_RIGHT_THRESHOLD, {4'($urandom), 12'(rt)});
        write_reg(REG_PROP_GAIN, 16'(pg));
        write_reg(REG_DERIV_GAIN, 16'(dg));
        write_reg(REG_BASE_RATE, {4'($urandom), 12'(br)});
        write_reg(REG_MIN_RATE, {4'($urandom), 12'(mn)});
        write_reg(REG_MAX_RATE, {4'($urandom), 12'(mx)});
    endtask

    // Hold until every scan is taken and every wheel beat has come back;
    // look at the falling edge so that the driver's updates have settled
    task automatic settle();
        do @(negedge i_clk);
        while (scan_q.size() != 0 || s_axis_tvalid || wheel_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly a mid sensor drifting near the set point, the rest pure noise
    task automatic queue_random_scans(input int count);
        int mid;
        mid = plan_mid;
        repeat (count) begin
            if ($urandom_range(9, 0) < 3) begin
                scan_q.push_back(pack_scan(12'($urandom), 12'($urandom), 12'($urandom)));
            end else begin
                if ($urandom_range(15, 0) == 0)
                    mid = $urandom_range(4095, 0);
                else if ($urandom_range(7, 0) == 0)
                    mid = plan_mid + int'($urandom_range(64, 0)) - 32;
                else
                    mid = mid + int'($urandom_range(128, 0)) - 64;
                if (mid < 0)
                    mid = 0;
                if (mid > 4095)
                    mid = 4095;
                scan_q.push_back(pack_scan(12'(edge_code(plan_lthr)), 12'(mid),
                                           12'(edge_code(plan_rthr))));
            end
        end
    endtask

    initial begin
        int lo;
        int hi;
        int sel;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: straight, extremes, each trigger and its boundary
        scan_q.push_back(pack_scan(12'd4095, 12'd3102, 12'd4095));
        scan_q.push_back(pack_scan(12'd4095, 12'd4095, 12'd4095));
        scan_q.push_back(pack_scan(12'd4095, 12'd0, 12'd4095));
        scan_q.push_back(pack_scan(12'd0, 12'd3102, 12'd4095));
        scan_q.push_back(pack_scan(12'd4095, 12'd3102, 12'd0));
        scan_q.push_back(pack_scan(12'd0, 12'd0, 12'd0));
        scan_q.push_back(pack_scan(12'd3411, 12'd3102, 12'd4095));
        scan_q.push_back(pack_scan(12'd3412, 12'd3102, 12'd3102));
        scan_q.push_back(pack_scan(12'd3412, 12'd3102, 12'd3101));
        scan_q.push_back(pack_scan(12'd3500, 12'd3200, 12'd3500));
        scan_q.push_back(pack_scan(12'd3500, 12'd3000, 12'd3500));
        scan_q.push_back(pack_scan(12'd3500, 12'd3103, 12'd3500));
        settle();

        // Full gains, widest rates, minimum register below the floor
        set_all(4095, 0, 0, 65535, 65535, 4095, 0, 4095);
        scan_q.push_back(pack_scan(12'd0, 12'd0, 12'd0));
        scan_q.push_back(pack_scan(12'd4095, 12'd4095, 12'd4095));
        scan_q.push_back(pack_scan(12'd0, 12'd0, 12'd0));
        scan_q.push_back(pack_scan(12'd2048, 12'd2048, 12'd2048));
        scan_q.push_back(pack_scan(12'd4095, 12'd4095, 12'd4095));
        scan_q.push_back(pack_scan(12'd4095, 12'd4095, 12'd4095));
        settle();

        // Minimum above maximum, derivative only, thresholds at the top
        set_all(0, 4095, 4095, 0, 65535, 31, 4095, 31);
        scan_q.push_back(pack_scan(12'd4095, 12'd0, 12'd4095));
        scan_q.push_back(pack_scan(12'd4094, 12'd4095, 12'd4095));
        scan_q.push_back(pack_scan(12'd4095, 12'd0, 12'd0));
        scan_q.push_back(pack_scan(12'd4095, 12'd4095, 12'd4095));
        scan_q.push_back(pack_scan(12'd4095, 12'd100, 12'd4095));
        settle();

        // Random settings, each followed by a batch of scans
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            lo = rand_rate();
            hi = rand_rate();
            sel = $urandom_range(7, 0);
            if ((sel < 5 && lo > hi) || (sel == 5 && lo < hi)) begin
                lo = lo ^ hi;
                hi = lo ^ hi;
                lo = lo ^ hi;
            end
            if (sel == 6)
                lo = $urandom_range(30, 0);
            if (sel == 7)
                hi = $urandom_range(30, 0);
            case ($urandom_range(2, 0))
                0: sel = $urandom_range(600, 31);
                1: sel = $urandom_range(4095, 0);
                default: sel = $urandom_range(300, 31);
            endcase
            set_all($urandom_range(4095, 0), rand_thr(), rand_thr(), rand_gain(),
                    rand_gain(), sel, lo, hi);
            queue_random_scans(SCANS_PER_PHASE);
            settle();
        end

        if (fail_count == 0 && wheel_q.size() == 0)
            $display("[differential_drive_pd_steering] OK");
        else
            $display("[differential_drive_pd_steering] ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #40_000_000;
        $display("[differential_drive_pd_steering] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/ddps_pkg.sv
rtl/core/ddps_div.sv
rtl/core/differential_drive_pd_steering.sv
bench/tb_top.sv
